@@ rtl/core/ffa_pkg.sv @@
// Shared types and constants for the first-fit heap allocator
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;

  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned SIZE_W     = 21;
  localparam int unsigned OFF_W      = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam logic [SIZE_W-1:0] HEAP_LIMIT = 21'd1048576;
  localparam logic [SIZE_W-1:0] HEAP_RESET = 21'd65536;
  localparam logic [SIZE_W:0]   MIN_SPLIT  = 22'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BYTES = 2'd1;

  typedef struct packed {
    logic              is_free;
    logic [SIZE_W-1:0] payload;
    logic [OFF_W-1:0]  offset;
  } entry_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_IGNORED = 2'd1,
    STS_NO_FIT  = 2'd2,
    STS_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_LOAD,
    OP_READ_IDX,
    OP_SCAN_NEXT,
    OP_SCAN_HIT,
    OP_ALLOC_WHOLE,
    OP_SHIFT_INIT,
    OP_SHIFT_RD,
    OP_SHIFT_WR,
    OP_SPLIT_TAIL,
    OP_SPLIT_HEAD,
    OP_FREE_MARK,
    OP_NEXT_RD,
    OP_NEXT_MERGE,
    OP_RM_RD,
    OP_RM_WR,
    OP_RM_DONE,
    OP_PREV_MERGE
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    logic    set_status;
    status_e status;
    logic    res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mode_free;
    logic req_zero;
    logic addr_zero;
    logic hit;
    logic last;
    logic split;
    logic shift_done;
    logic has_next;
    logic next_free;
    logic prev_free;
    logic rm_last;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/ffa_ctrl.sv @@
// Sequencer for scan, split, mark and merge passes of the allocator
`timescale 1ns / 1ps
`default_nettype none
module ffa_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  input  ffa_pkg::dp_stat_t  stat_i,
  output ffa_pkg::ctrl_cmd_t cmd_o
);
  import ffa_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_START, S_RD, S_CHK, S_A_DEC, S_SH_RD, S_SH_WR, S_SPL_H,
    S_F_MARK, S_F_NRD, S_F_NCHK, S_RM_RD, S_RM_WR, S_F_PREV, S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   ret_prev_q, ret_prev_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    ret_prev_d  = ret_prev_q;
    out_valid_d = out_valid_q & out_stall_i;
    cmd_o       = '{op: OP_NONE, set_status: 1'b0, status: STS_OK, res_load: 1'b0};
    case (state_q)
      S_INIT: begin
        cmd_o.op = OP_INIT;
        state_d  = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_START;
        end
      end
      S_START: begin
        if ((!stat_i.mode_free && stat_i.req_zero) || (stat_i.mode_free && stat_i.addr_zero)) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STS_IGNORED;
          state_d          = S_FINISH;
        end else begin
          cmd_o.op = OP_READ_IDX;
          state_d  = S_CHK;
        end
      end
      S_RD: begin
        cmd_o.op = OP_READ_IDX;
        state_d  = S_CHK;
      end
      S_CHK: begin
        if (stat_i.hit) begin
          cmd_o.op = OP_SCAN_HIT;
          state_d  = stat_i.mode_free ? S_F_MARK : S_A_DEC;
        end else if (stat_i.last) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = stat_i.mode_free ? STS_UNKNOWN : STS_NO_FIT;
          state_d          = S_FINISH;
        end else begin
          cmd_o.op = OP_SCAN_NEXT;
          state_d  = S_RD;
        end
      end
      S_A_DEC: begin
        cmd_o.set_status = 1'b1;
        cmd_o.status     = STS_OK;
        if (stat_i.split) begin
          cmd_o.op = OP_SHIFT_INIT;
          state_d  = S_SH_RD;
        end else begin
          cmd_o.op = OP_ALLOC_WHOLE;
          state_d  = S_FINISH;
        end
      end
      S_SH_RD: begin
        if (stat_i.shift_done) begin
          cmd_o.op = OP_SPLIT_TAIL;
          state_d  = S_SPL_H;
        end else begin
          cmd_o.op = OP_SHIFT_RD;
          state_d  = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd_o.op = OP_SHIFT_WR;
        state_d  = S_SH_RD;
      end
      S_SPL_H: begin
        cmd_o.op = OP_SPLIT_HEAD;
        state_d  = S_FINISH;
      end
      S_F_MARK: begin
        cmd_o.op         = OP_FREE_MARK;
        cmd_o.set_status = 1'b1;
        cmd_o.status     = STS_OK;
        state_d          = stat_i.has_next ? S_F_NRD : S_F_PREV;
      end
      S_F_NRD: begin
        cmd_o.op = OP_NEXT_RD;
        state_d  = S_F_NCHK;
      end
      S_F_NCHK: begin
        if (stat_i.next_free) begin
          cmd_o.op   = OP_NEXT_MERGE;
          ret_prev_d = 1'b1;
          state_d    = S_RM_RD;
        end else begin
          state_d = S_F_PREV;
        end
      end
      S_RM_RD: begin
        if (stat_i.rm_last) begin
          cmd_o.op = OP_RM_DONE;
          state_d  = ret_prev_q ? S_F_PREV : S_FINISH;
        end else begin
          cmd_o.op = OP_RM_RD;
          state_d  = S_RM_WR;
        end
      end
      S_RM_WR: begin
        cmd_o.op = OP_RM_WR;
        state_d  = S_RM_RD;
      end
      S_F_PREV: begin
        if (stat_i.prev_free) begin
          cmd_o.op   = OP_PREV_MERGE;
          ret_prev_d = 1'b0;
          state_d    = S_RM_RD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
      ret_prev_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ret_prev_q  <= ret_prev_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ffa_dp.sv @@
// Block table memory, counters and arithmetic of the allocator
`timescale 1ns / 1ps
`default_nettype none
module ffa_dp #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  ffa_pkg::ctrl_cmd_t                 cmd_i,
  output ffa_pkg::dp_stat_t                  stat_o,
  input  wire                                mode_i,
  input  wire [ffa_pkg::SIZE_W-1:0]          req_size_i,
  input  wire [ffa_pkg::ADDR_W-1:0]          payload_address_i,
  input  wire                                cfg_valid_i,
  input  wire [ffa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire [ffa_pkg::ADDR_W-1:0]          cfg_data_i,
  output logic [1:0]                         status_o,
  output logic [ffa_pkg::ADDR_W-1:0]         address_o,
  output logic [ffa_pkg::SIZE_W-1:0]         allocated_bytes_o,
  output logic [ffa_pkg::SIZE_W-1:0]         free_sum_o
);
  import ffa_pkg::*;

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [SIZE_W-1:0] HDR = SIZE_W'(HEADER_BYTES);
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

  entry_t mem [MAX_BLOCKS];
  entry_t rdata_q, prev_q, hit_e_q, hit_e_d, wr_data;
  logic   rd_en, wr_en;
  logic [IW-1:0] rd_idx, wr_idx;

  logic [ADDR_W-1:0] base_q, base_d, addr_q, res_addr_q, wk_addr_q, wk_addr_d;
  logic [ADDR_W-1:0] ent_addr, hit_addr;
  logic [SIZE_W-1:0] hbytes_q, hbytes_d, alloc_q, alloc_d, free_q, free_d;
  logic [SIZE_W-1:0] res_alloc_q, res_free_q, new_hb, clamp_hb, p0;
  logic [SIZE_W:0]   size_q, size_d, sat_sum, sat_in;
  logic [CW-1:0]     count_q, count_d, idx_q, idx_d, j_q, j_d, hit_c;
  logic [IW-1:0]     hit_q, hit_d;
  logic              mode_q, mode_d, req_zero_q, req_zero_d;
  status_e           status_q, res_status_q;
  logic              cfg_we, reinit;
  logic [SIZE_W-1:0] merged;

  assign hit_c    = CW'(hit_q);
  assign cfg_we   = cfg_valid_i && (cfg_index_i == CFG_HEAP_BASE || cfg_index_i == CFG_HEAP_BYTES);
  assign reinit   = cfg_we || (cmd_i.op == OP_INIT);
  assign new_hb   = (cfg_valid_i && cfg_index_i == CFG_HEAP_BYTES) ? cfg_data_i[SIZE_W-1:0]
                                                                    : hbytes_q;
  assign clamp_hb = (new_hb > HEAP_LIMIT) ? HEAP_LIMIT : new_hb;
  assign p0       = (clamp_hb > HDR) ? clamp_hb - HDR : '0;
  assign ent_addr = base_q + ADDR_W'(rdata_q.offset) + ADDR_W'(HEADER_BYTES);
  assign hit_addr = base_q + ADDR_W'(hit_e_q.offset) + ADDR_W'(HEADER_BYTES);
  assign merged   = hit_e_q.payload + HDR + rdata_q.payload;
  assign sat_sum  = {1'b0, alloc_q} + sat_in;

  always_comb begin
    stat_o.mode_free  = mode_q;
    stat_o.req_zero   = req_zero_q;
    stat_o.addr_zero  = (addr_q == '0);
    stat_o.hit        = mode_q ? (ent_addr == addr_q)
                               : (rdata_q.is_free && ({1'b0, rdata_q.payload} >= size_q));
    stat_o.last       = ({1'b0, idx_q} + 1'b1) >= {1'b0, count_q};
    stat_o.split      = ({2'b0, hit_e_q.payload} >= ({1'b0, size_q} + {2'b0, HDR}
                         + {1'b0, MIN_SPLIT})) && (count_q < MAXC);
    stat_o.shift_done = (j_q == hit_c + 1'b1);
    stat_o.has_next   = ({1'b0, hit_c} + 1'b1) < {1'b0, count_q};
    stat_o.next_free  = rdata_q.is_free;
    stat_o.prev_free  = (hit_q != '0) && prev_q.is_free;
    stat_o.rm_last    = ({1'b0, j_q} + 1'b1) >= {1'b0, count_q};
  end

  always_comb begin
    base_d     = base_q;
    hbytes_d   = hbytes_q;
    alloc_d    = alloc_q;
    free_d     = free_q;
    count_d    = count_q;
    idx_d      = idx_q;
    j_d        = j_q;
    hit_d      = hit_q;
    hit_e_d    = hit_e_q;
    size_d     = size_q;
    mode_d     = mode_q;
    req_zero_d = req_zero_q;
    wk_addr_d  = wk_addr_q;
    rd_en      = 1'b0;
    rd_idx     = idx_q[IW-1:0];
    wr_en      = 1'b0;
    wr_idx     = hit_q;
    wr_data    = hit_e_q;
    sat_in     = {1'b0, hit_e_q.payload};
    case (cmd_i.op)
      OP_LOAD: begin
        mode_d     = mode_i;
        req_zero_d = (req_size_i == '0);
        size_d     = ({1'b0, req_size_i} + (SIZE_W+1)'(15)) & ~(SIZE_W+1)'(15);
        idx_d      = '0;
        wk_addr_d  = '0;
      end
      OP_READ_IDX: rd_en = 1'b1;
      OP_SCAN_NEXT: idx_d = idx_q + 1'b1;
      OP_SCAN_HIT: begin
        hit_d   = idx_q[IW-1:0];
        hit_e_d = rdata_q;
      end
      OP_ALLOC_WHOLE: begin
        wr_en      = 1'b1;
        wr_data    = '{is_free: 1'b0, payload: hit_e_q.payload, offset: hit_e_q.offset};
        alloc_d    = sat_sum[SIZE_W] ? '1 : sat_sum[SIZE_W-1:0];
        free_d     = free_q - hit_e_q.payload;
        wk_addr_d  = hit_addr;
      end
      OP_SHIFT_INIT: j_d = count_q;
      OP_SHIFT_RD: begin
        rd_en  = 1'b1;
        rd_idx = IW'(j_q - 1'b1);
      end
      OP_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_idx  = j_q[IW-1:0];
        wr_data = rdata_q;
        j_d     = j_q - 1'b1;
      end
      OP_SPLIT_TAIL: begin
        wr_en   = 1'b1;
        wr_idx  = hit_q + 1'b1;
        wr_data = '{is_free: 1'b1,
                    payload: hit_e_q.payload - size_q[SIZE_W-1:0] - HDR,
                    offset:  hit_e_q.offset + OFF_W'(HDR) + OFF_W'(size_q)};
      end
      OP_SPLIT_HEAD: begin
        wr_en      = 1'b1;
        wr_data    = '{is_free: 1'b0, payload: size_q[SIZE_W-1:0], offset: hit_e_q.offset};
        count_d    = count_q + 1'b1;
        sat_in     = size_q;
        alloc_d    = sat_sum[SIZE_W] ? '1 : sat_sum[SIZE_W-1:0];
        free_d     = free_q - size_q[SIZE_W-1:0] - HDR;
        wk_addr_d  = hit_addr;
      end
      OP_FREE_MARK: begin
        wr_en           = 1'b1;
        wr_data         = '{is_free: 1'b1, payload: hit_e_q.payload, offset: hit_e_q.offset};
        hit_e_d.is_free = 1'b1;
        if (alloc_q >= hit_e_q.payload) alloc_d = alloc_q - hit_e_q.payload;
        if (!hit_e_q.is_free) free_d = free_q + hit_e_q.payload;
      end
      OP_NEXT_RD: begin
        rd_en  = 1'b1;
        rd_idx = hit_q + 1'b1;
      end
      OP_NEXT_MERGE: begin
        wr_en           = 1'b1;
        wr_data         = '{is_free: 1'b1, payload: merged, offset: hit_e_q.offset};
        hit_e_d.payload = merged;
        free_d          = free_q + HDR;
        j_d             = hit_c + 1'b1;
      end
      OP_RM_RD: begin
        rd_en  = 1'b1;
        rd_idx = IW'(j_q + 1'b1);
      end
      OP_RM_WR: begin
        wr_en   = 1'b1;
        wr_idx  = j_q[IW-1:0];
        wr_data = rdata_q;
        j_d     = j_q + 1'b1;
      end
      OP_RM_DONE: count_d = count_q - 1'b1;
      OP_PREV_MERGE: begin
        wr_en   = 1'b1;
        wr_idx  = hit_q - 1'b1;
        wr_data = '{is_free: 1'b1, payload: prev_q.payload + HDR + hit_e_q.payload,
                    offset: prev_q.offset};
        free_d  = free_q + HDR;
        j_d     = hit_c;
      end
      default: ;
    endcase
    if (cfg_valid_i && cfg_index_i == CFG_HEAP_BASE) base_d = cfg_data_i;
    hbytes_d = new_hb;
    if (reinit) begin
      wr_en   = 1'b1;
      wr_idx  = '0;
      wr_data = '{is_free: 1'b1, payload: p0, offset: '0};
      count_d = CW'(1);
      alloc_d = '0;
      free_d  = p0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SCAN_NEXT) prev_q <= rdata_q;
    if (cmd_i.op == OP_LOAD) addr_q <= payload_address_i;
    hit_e_q   <= hit_e_d;
    hit_q     <= hit_d;
    size_q    <= size_d;
    wk_addr_q <= wk_addr_d;
    if (cmd_i.res_load) begin
      res_status_q <= status_q;
      res_addr_q   <= wk_addr_q;
      res_alloc_q  <= alloc_q;
      res_free_q   <= free_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= '0;
      hbytes_q   <= HEAP_RESET;
      alloc_q    <= '0;
      free_q     <= HEAP_RESET - HDR;
      count_q    <= CW'(1);
      idx_q      <= '0;
      j_q        <= '0;
      mode_q     <= 1'b0;
      req_zero_q <= 1'b0;
      status_q   <= STS_OK;
    end else begin
      base_q     <= base_d;
      hbytes_q   <= hbytes_d;
      alloc_q    <= alloc_d;
      free_q     <= free_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      j_q        <= j_d;
      mode_q     <= mode_d;
      req_zero_q <= req_zero_d;
      if (cmd_i.set_status) status_q <= cmd_i.status;
    end
  end

  assign status_o          = res_status_q;
  assign address_o         = res_addr_q;
  assign allocated_bytes_o = res_alloc_q;
  assign free_sum_o        = res_free_q;

endmodule
`default_nettype wire

@@ rtl/core/first_fit_heap_allocator.sv @@
// Top level of the first-fit heap allocator with coalescing
// Each table entry scanned by the first-fit or address search takes a read and a
// check state, each entry moved when a split or merge shifts the block table takes
// a read and a write state, and set-up and result add the start and finish states.
// One request is in work at a time; the result register frees the input side.
// Reset is asynchronous, active low; entry 0 is written in the first cycle after it.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_heap_allocator #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire                          mode_i,
  input  wire [ffa_pkg::SIZE_W-1:0]    req_size_i,
  input  wire [ffa_pkg::ADDR_W-1:0]    payload_address_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [1:0]                   status_o,
  output logic [ffa_pkg::ADDR_W-1:0]   address_o,
  output logic [ffa_pkg::SIZE_W-1:0]   allocated_bytes_o,
  output logic [ffa_pkg::SIZE_W-1:0]   free_sum_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [ffa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire [ffa_pkg::ADDR_W-1:0]    cfg_data_i
);
  import ffa_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ffa_dp #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .mode_i            (mode_i),
    .req_size_i        (req_size_i),
    .payload_address_i (payload_address_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .status_o          (status_o),
    .address_o         (address_o),
    .allocated_bytes_o (allocated_bytes_o),
    .free_sum_o        (free_sum_o)
  );

endmodule
`default_nettype wire

@@ bench/tb_first_fit_heap_allocator.sv @@
// Self-checking testbench for the first-fit heap allocator
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator;
  import ffa_pkg::*;

  localparam int unsigned NBLK = 64;
  localparam int unsigned HDR  = 24;
  localparam int unsigned NRAND = 1250;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] alloc_b;
    logic [SIZE_W-1:0] free_b;
  } heap_result_t;

  int unsigned n_errors = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    n_errors++;
  endtask

  class heap_scoreboard;
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] bytes;
    logic [OFF_W-1:0]  offs[NBLK];
    logic [SIZE_W-1:0] pay[NBLK];
    bit                frees[NBLK];
    int unsigned       count;
    logic [SIZE_W-1:0] alloc_total;
    heap_result_t      pending[$];
    logic [ADDR_W-1:0] live[$];

    function void reinit();
      logic [SIZE_W-1:0] sz;
      sz = (bytes > HEAP_LIMIT) ? HEAP_LIMIT : bytes;
      offs[0] = '0;
      pay[0] = (sz > HDR) ? sz - HDR : '0;
      frees[0] = 1;
      count = 1;
      alloc_total = '0;
      live.delete();
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] d);
      if (idx == CFG_HEAP_BASE) begin
        base = d;
        reinit();
      end else if (idx == CFG_HEAP_BYTES) begin
        bytes = d[SIZE_W-1:0];
        reinit();
      end
    endfunction

    function logic [ADDR_W-1:0] pay_addr(input int i);
      return base + offs[i] + HDR;
    endfunction

    function void drop(input int idx);
      for (int k = idx; k + 1 < count; k++) begin
        offs[k] = offs[k+1]; pay[k] = pay[k+1]; frees[k] = frees[k+1];
      end
      count--;
    endfunction

    function void note_request(input logic mode, input logic [SIZE_W-1:0] req,
                               input logic [ADDR_W-1:0] pa);
      heap_result_t r;
      logic [63:0] sz, t;
      int i;
      bit done;
      r = '0;
      done = 0;
      if (!mode) begin
        if (req == 0) r.status = STS_IGNORED;
        else begin
          sz = (64'(req) + 15) & ~64'd15;
          for (i = 0; i < count && !done; i++) begin
            if (frees[i] && 64'(pay[i]) >= sz) begin
              if (64'(pay[i]) >= sz + HDR + 16 && count < NBLK) begin
                for (int k = count; k > i + 1; k--) begin
                  offs[k] = offs[k-1]; pay[k] = pay[k-1]; frees[k] = frees[k-1];
                end
                offs[i+1] = offs[i] + HDR + sz[OFF_W-1:0];
                pay[i+1] = pay[i] - sz[SIZE_W-1:0] - HDR;
                frees[i+1] = 1;
                pay[i] = sz[SIZE_W-1:0];
                count++;
              end
              frees[i] = 0;
              t = 64'(alloc_total) + pay[i];
              alloc_total = (t > 64'h1FFFFF) ? 21'h1FFFFF : t[SIZE_W-1:0];
              r.status = STS_OK;
              r.address = pay_addr(i);
              live.push_back(r.address);
              done = 1;
            end
          end
          if (!done) r.status = STS_NO_FIT;
        end
      end else begin
        if (pa == 0) r.status = STS_IGNORED;
        else begin
          r.status = STS_UNKNOWN;
          for (i = 0; i < count && !done; i++) begin
            if (pay_addr(i) == pa) begin
              frees[i] = 1;
              if (alloc_total >= pay[i]) alloc_total -= pay[i];
              i = 0;
              while (i + 1 < count) begin
                if (frees[i] && frees[i+1]) begin
                  pay[i] += HDR + pay[i+1];
                  drop(i + 1);
                end else i++;
              end
              r.status = STS_OK;
              done = 1;
            end
          end
        end
      end
      r.alloc_b = alloc_total;
      r.free_b = '0;
      for (i = 0; i < count; i++) if (frees[i]) r.free_b += pay[i];
      pending.push_back(r);
    endfunction

    task check_result(input heap_result_t got);
      heap_result_t w;
      if (pending.size() == 0) begin
        report("unexpected result", got.address, 0);
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) report("status", got.status, w.status);
      if (got.address !== w.address) report("address", got.address, w.address);
      if (got.alloc_b !== w.alloc_b) report("allocated_bytes", got.alloc_b, w.alloc_b);
      if (got.free_b !== w.free_b) report("free_sum", got.free_b, w.free_b);
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic mode_i = 0;
  logic [SIZE_W-1:0] req_size_i = '0;
  logic [ADDR_W-1:0] payload_address_i = '0;
  logic out_stall_i = 1;
  logic cfg_valid_i = 0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ADDR_W-1:0] cfg_data_i = '0;
  wire in_stall_o, out_valid_o, cfg_ready_o;
  wire [1:0] status_o;
  wire [ADDR_W-1:0] address_o;
  wire [SIZE_W-1:0] allocated_bytes_o, free_sum_o;

  first_fit_heap_allocator #(.MAX_BLOCKS(NBLK), .HEADER_BYTES(HDR)) dut (.*);

  heap_scoreboard heap_sb = new();
  bit hold_off = 0;
  bit stim_done = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_req(input logic m, input logic [SIZE_W-1:0] rq,
                          input logic [ADDR_W-1:0] pa);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1;
    mode_i <= m;
    req_size_i <= rq;
    payload_address_i <= pa;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    heap_sb.note_request(m, rq, pa);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (heap_sb.pending.size() != 0) @(posedge clk_i);
    repeat (4 * NBLK + 20) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] d);
    drain();
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    heap_sb.write_reg(idx, d);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic send_free_live();
    int k;
    logic [ADDR_W-1:0] a;
    if (heap_sb.live.size() == 0) begin
      send_req(1, '0, {$urandom, $urandom});
      return;
    end
    k = $urandom_range(0, heap_sb.live.size() - 1);
    a = heap_sb.live[k];
    if ($urandom_range(0, 9) != 0) heap_sb.live.delete(k);
    send_req(1, '0, a);
  endtask

  task automatic random_op();
    int p;
    logic [SIZE_W-1:0] sz;
    p = $urandom_range(0, 99);
    if (p < 8) sz = $urandom_range(1, 16);
    else if (p < 12) sz = {$urandom} & 21'h1FFFFF;
    else sz = $urandom_range(1, 600);
    p = $urandom_range(0, 99);
    if (p < 50) send_req(0, sz, {$urandom, $urandom});
    else if (p < 88) send_free_live();
    else if (p < 93) send_req(1, '0, {$urandom, $urandom});
    else if (p < 96) send_req($urandom_range(0, 1), '0, '0);
    else send_req(1, '0, heap_sb.base + HDR + ($urandom_range(0, 64) << 4));
  endtask

  initial begin
    heap_sb.base = '0;
    heap_sb.bytes = HEAP_RESET;
    heap_sb.reinit();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_req(0, 21'd1, 48'd5);
    send_req(0, 21'd16, '0);
    send_req(0, 21'd17, '0);
    send_req(0, '0, '0);
    send_req(1, '0, '0);
    send_req(0, 21'h1FFFFF, 48'hFFFF_FFFF_FFFF);
    send_req(0, 21'd1048576, '0);
    send_req(1, '0, 48'hFFFF_FFFF_FFFF);
    send_req(1, '0, 48'd24);
    send_req(1, '0, 48'd24);
    send_req(1, '0, 48'd64);
    send_req(0, 21'd65512, '0);
    send_req(1, '0, 48'd24);
    write_cfg(CFG_HEAP_BYTES, 48'd64);
    send_req(0, 21'd40, '0);
    send_req(0, 21'd16, '0);
    write_cfg(CFG_HEAP_BYTES, 48'd16);
    send_req(0, 21'd1, '0);
    write_cfg(CFG_HEAP_BYTES, 48'hFFFF_FFFF_FFFF);
    send_req(0, 21'd1048576, '0);
    write_cfg(CFG_HEAP_BASE, 48'hFFFF_FFFF_FFF0);
    send_req(0, 21'd8, '0);
    send_req(1, '0, 48'd8);
    write_cfg(2'd3, 48'd1);
    send_req(0, 21'd8, '0);
    write_cfg(CFG_HEAP_BASE, '0);
    write_cfg(CFG_HEAP_BYTES, 48'd4096);
    for (int i = 0; i < 80; i++) send_req(0, 21'd16, '0);
    for (int i = 0; i < 70; i++) send_free_live();
    drain();
    for (int n = 0; n < NRAND; n++) begin
      if (n % 350 == 349) begin
        case ($urandom_range(0, 2))
          0: write_cfg(CFG_HEAP_BASE, {$urandom, $urandom} & 48'hFFFF_FFFF_FFF0);
          1: write_cfg(CFG_HEAP_BYTES, $urandom_range(64, 1048576));
          default: write_cfg(CFG_HEAP_BYTES, $urandom_range(2048, 20000));
        endcase
      end
      if (n == 600) hold_off = 1;
      if (n == 900) drain();
      random_op();
    end
    stim_done = 1;
  end

  initial begin
    int g;
    out_stall_i <= 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        hold_off = 0;
        out_stall_i <= 1;
        repeat (400) @(posedge clk_i);
        out_stall_i <= 0;
      end else if (!stim_done && $urandom_range(0, 99) < 20) begin
        g = gap_len();
        if (g > 0) begin
          out_stall_i <= 1;
          repeat (g) @(posedge clk_i);
          out_stall_i <= 0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      heap_sb.check_result('{status_o, address_o, allocated_bytes_o, free_sum_o});
  end

  initial begin
    wait (stim_done);
    drain();
    if (n_errors == 0 && heap_sb.pending.size() == 0) $display("tb_first_fit_heap_allocator OK");
    else $display("tb_first_fit_heap_allocator NOT OK");
    $finish;
  end

  initial begin
    #50ms;
    $display("tb_first_fit_heap_allocator NOT OK");
    $finish;
  end
endmodule
